[hw/rtl/base32_hyphen_encoder_unit_macros.svh]
// Assertion macros for the base32 hyphen encoder.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef BASE32_HYPHEN_ENCODER_UNIT_MACROS_SVH
`define BASE32_HYPHEN_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define B32H_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define B32H_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/b32h_pkg.sv]
// Constants and helpers for the base32 hyphen encoder.
// No dependencies.
`timescale 1ns / 1ps

package b32h_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CharW    = 7;
  localparam int unsigned SymW     = 5;
  localparam int unsigned BlockW   = 40;
  localparam int unsigned AccW     = 32;
  localparam int unsigned LbitsW   = 4;
  localparam int unsigned CntW     = 3;
  localparam int unsigned NsymW    = 4;
  localparam int unsigned GrpSize  = 4;

  localparam logic [CharW-1:0] HyphenChar = 7'd45;
  localparam logic [CharW-1:0] LetterBase = 7'd97;   // 'a'
  localparam logic [CharW-1:0] DigitBase  = 7'd50;   // '2'
  localparam logic [CntW-1:0]  FullBytes  = 3'd4;    // bytes held before the fifth
  localparam logic [NsymW-1:0] FullSyms   = 4'd8;

  // 5-bit symbol to lowercase base32 character.
  function automatic logic [CharW-1:0] sym_char(input logic [SymW-1:0] s);
    logic [CharW-1:0] v;
    v = {2'b00, s};
    if (s < 5'd26) begin
      sym_char = LetterBase + v;
    end else begin
      sym_char = DigitBase + (v - 7'd26);
    end
  endfunction

  // ceil(bits / 5) for bits in 1..40, as floor((bits + 4) * 13 / 64).
  function automatic logic [NsymW-1:0] sym_count(input logic [5:0] bits);
    logic [5:0] x;
    logic [9:0] p;
    x = bits + 6'd4;
    p = {4'b0000, x} * 10'd13;
    sym_count = p[9:6];
  endfunction

endpackage

[hw/rtl/base32_hyphen_encoder_unit.sv]
// Base32 (lowercase, unpadded) encoder with a hyphen after every four symbols.
// Depends on b32h_pkg and base32_hyphen_encoder_unit_macros.svh.
//
// Bytes enter at up to one per cycle while in_ready_o is high; four of every
// five are only shifted into a 32-bit holding register. The fifth byte of a
// block, or a byte flagged last, hands the padded 40-bit block to an output
// shifter that sends one character per cycle (symbols and hyphens), unless
// out_ready_i stalls it, through a registered output port. A full block gives
// 9 or 10 characters, so sustained throughput is set by that shifter. A
// block-completing byte is taken in the same cycle the previous block's last
// symbol leaves: no gap. end_of_text_o marks the last character of a message.
`timescale 1ns / 1ps
`include "base32_hyphen_encoder_unit_macros.svh"

module base32_hyphen_encoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [b32h_pkg::ByteW-1:0]  data_byte_i,
  input  logic                        last_byte_i,
  input  logic [b32h_pkg::LbitsW-1:0] last_bits_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [b32h_pkg::CharW-1:0]  out_char_o,
  output logic                        end_of_text_o
);
  import b32h_pkg::*;

  // Input side
  logic [AccW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]   bytes_q, bytes_d;

  // Output shifter
  logic              ser_busy_q, ser_busy_d;
  logic [BlockW-1:0] ser_blk_q, ser_blk_d;
  logic [NsymW-1:0]  ser_rem_q, ser_rem_d;
  logic              ser_last_q, ser_last_d;
  logic [CntW-1:0]   grp_q, grp_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  out_char_q, out_char_d;
  logic              eot_q, eot_d;

  logic              in_xfer, need_ser, advance, hyph, ser_done;
  logic [LbitsW-1:0] lbits;
  logic [5:0]        msg_bits;
  logic [5:0]        pad_sh;
  logic [BlockW-1:0] new_blk;
  logic [NsymW-1:0]  new_nsym;

  assign need_ser   = last_byte_i || (bytes_q == FullBytes);
  assign advance    = ser_busy_q && (!out_valid_q || out_ready_i);
  assign hyph       = (grp_q == CntW'(GrpSize));
  assign ser_done   = advance && !hyph && (ser_rem_q == NsymW'(1));
  assign in_ready_o = !need_ser || !ser_busy_q || ser_done;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    if (last_bits_i == '0) begin
      lbits = LbitsW'(1);
    end else if (last_bits_i > LbitsW'(8)) begin
      lbits = LbitsW'(8);
    end else begin
      lbits = last_bits_i;
    end
    msg_bits = {bytes_q, 3'b000} + {2'b00, lbits};
    pad_sh   = {FullBytes - bytes_q, 3'b000};
    new_blk  = {acc_q, data_byte_i} << pad_sh;
    new_nsym = last_byte_i ? sym_count(msg_bits) : FullSyms;
  end

  always_comb begin
    acc_d   = acc_q;
    bytes_d = bytes_q;
    if (in_xfer) begin
      if (need_ser) begin
        acc_d   = '0;
        bytes_d = '0;
      end else begin
        acc_d   = {acc_q[AccW-ByteW-1:0], data_byte_i};
        bytes_d = bytes_q + CntW'(1);
      end
    end
  end

  always_comb begin
    ser_busy_d = ser_busy_q;
    ser_blk_d  = ser_blk_q;
    ser_rem_d  = ser_rem_q;
    ser_last_d = ser_last_q;
    grp_d      = grp_q;
    if (advance) begin
      if (hyph) begin
        grp_d = '0;
      end else begin
        grp_d     = (ser_done && ser_last_q) ? '0 : grp_q + CntW'(1);
        ser_blk_d = ser_blk_q << SymW;
        ser_rem_d = ser_rem_q - NsymW'(1);
        if (ser_done) begin
          ser_busy_d = 1'b0;
        end
      end
    end
    if (in_xfer && need_ser) begin
      ser_busy_d = 1'b1;
      ser_blk_d  = new_blk;
      ser_rem_d  = new_nsym;
      ser_last_d = last_byte_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    eot_d       = eot_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_char_d  = hyph ? HyphenChar : sym_char(ser_blk_q[BlockW-1 -: SymW]);
      eot_d       = !hyph && ser_last_q && (ser_rem_q == NsymW'(1));
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      bytes_q     <= '0;
      ser_busy_q  <= 1'b0;
      ser_rem_q   <= '0;
      ser_last_q  <= 1'b0;
      grp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      bytes_q     <= bytes_d;
      ser_busy_q  <= ser_busy_d;
      ser_rem_q   <= ser_rem_d;
      ser_last_q  <= ser_last_d;
      grp_q       <= grp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ser_blk_q  <= ser_blk_d;
    out_char_q <= out_char_d;
    eot_q      <= eot_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign end_of_text_o = eot_q;

  `B32H_ASSERT_IMP(a_grp_range, 1'b1, grp_q <= CntW'(GrpSize), "group position above four")
  `B32H_ASSERT_IMP(a_rem_range, ser_busy_q, (ser_rem_q != '0) && (ser_rem_q <= FullSyms), "symbol count out of range")
  `B32H_ASSERT_IMP(a_no_overrun, in_xfer && need_ser, !ser_busy_q || ser_done, "block loaded over a busy shifter")
  `B32H_ASSERT_IMP(a_hyph_eot, out_valid_o && (out_char_o == HyphenChar), !end_of_text_o, "end of text on a hyphen")
  `B32H_ASSERT_NXT(a_eot_clears, ser_done && ser_last_q, (grp_q == '0) && end_of_text_o, "group not cleared after message end")

endmodule
